// ===== hw/rtl/smsq_pkg.sv =====
// Shared types, constants and the duty table for the microstep sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package smsq_pkg;

    localparam int unsigned POS_W   = 6;   // positions 0..63
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned SCALE_W = 3;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned CFG_W   = 16;  // widest register
    localparam int unsigned IDX_W   = 2;

    localparam logic [MODE_W-1:0]  MAX_MODE  = 3'd4;
    localparam logic [SCALE_W-1:0] MAX_SCALE = 3'd4;

    // register indexes of the config port
    localparam logic [IDX_W-1:0] REG_STEP_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_MOTOR_SPEED = 2'd1;
    localparam logic [IDX_W-1:0] REG_PWM_SCALE   = 2'd2;

    // one position word from the walker to the duty stage
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [POS_W-1:0] pos;
    } t_walk;

    // duty table: high byte and low byte per sub-position
    function automatic logic [15:0] duty_word(input logic [3:0] idx);
        logic [15:0] w;
        case (idx)
            4'd0:    w = 16'hFF00;
            4'd1:    w = 16'hFF2E;
            4'd2:    w = 16'hFF55;
            4'd3:    w = 16'hFF77;
            4'd4:    w = 16'hFF95;
            4'd5:    w = 16'hFFB2;
            4'd6:    w = 16'hFFCC;
            4'd7:    w = 16'hFFE6;
            4'd8:    w = 16'hFFFF;
            4'd9:    w = 16'hE6FF;
            4'd10:   w = 16'hCCFF;
            4'd11:   w = 16'hB2FF;
            4'd12:   w = 16'h95FF;
            4'd13:   w = 16'h77FF;
            4'd14:   w = 16'h55FF;
            4'd15:   w = 16'h2EFF;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smsq_walk.sv =====
// Position sequencer: one shared add/subtract steps the position by the stride.
// Depends on smsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smsq_walk (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire logic                      i_reverse,
    input  wire logic [smsq_pkg::MODE_W-1:0] i_mode,
    output logic                           busy,
    output smsq_pkg::t_walk                o_walk
);
    import smsq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state            r_state, n_state;
    logic              r_rev, n_rev;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic [POS_W-1:0]  stride;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  step_sum;
    logic              at_end;

    // stride = 16 >> mode
    assign stride   = POS_W'(5'd16 >> i_mode);
    // shared adder: forward adds the stride, reverse subtracts it
    assign step_sum = r_rev ? (r_pos - stride) : (r_pos + stride);
    assign end_pos  = r_rev ? '0 : POS_W'(7'd64 - {2'b00, stride[4:0]});
    assign at_end   = (r_pos == end_pos);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_rev   = r_rev;
        n_pos   = r_pos;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RUN;
                    n_rev   = i_reverse;
                    n_pos   = i_reverse ? POS_W'(7'd64 - {2'b00, stride[4:0]}) : '0;
                end
            end
            ST_RUN: begin
                n_pos = step_sum;
                if (at_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rev   <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_rev   <= n_rev;
            r_pos   <= n_pos;
        end
    end

    assign busy         = (r_state == ST_RUN);
    assign o_walk.valid = (r_state == ST_RUN);
    assign o_walk.last  = at_end;
    assign o_walk.pos   = r_pos;

endmodule

`default_nettype wire

// ===== hw/rtl/smsq_duty.sv =====
// Duty stage: table lookup, quarter rotation, scaling, and the output register.
// Depends on smsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smsq_duty (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire smsq_pkg::t_walk              i_walk,
    input  wire logic [smsq_pkg::SCALE_W-1:0] i_scale,
    input  wire logic [smsq_pkg::SPEED_W-1:0] i_hold,
    output logic                              o_strobe,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_a_duty,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_b_duty,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_c_duty,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_d_duty,
    output logic [smsq_pkg::SPEED_W-1:0]      o_hold_us,
    output logic                              o_last
);
    import smsq_pkg::*;

    logic [15:0]       word;
    logic [7:0]        hi, lo;
    logic [7:0]        b [4];
    logic [DUTY_W-1:0] d [4];

    assign word = duty_word(i_walk.pos[3:0]);
    assign hi   = word[15:8];
    assign lo   = word[7:0];

    // place the two bytes by coil quarter; last quarter wraps to coil a
    always_comb begin
        b[0] = '0;
        b[1] = '0;
        b[2] = '0;
        b[3] = '0;
        case (i_walk.pos[5:4])
            2'd0: begin b[2] = lo; b[3] = hi; end
            2'd1: begin b[1] = lo; b[2] = hi; end
            2'd2: begin b[0] = lo; b[1] = hi; end
            default: begin b[0] = hi; b[3] = lo; end
        endcase
    end

    // byte times scale (at most 4) fits 10 bits
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            d[k] = DUTY_W'({2'b00, b[k]} * {7'd0, i_scale});
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_walk.valid;
        end
        o_coil_a_duty <= d[0];
        o_coil_b_duty <= d[1];
        o_coil_c_duty <= d[2];
        o_coil_d_duty <= d[3];
        o_hold_us     <= i_hold;
        o_last        <= i_walk.last;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_microstep_sequencer.sv =====
// Top level: configuration registers, position sequencer and duty stage.
// Depends on smsq_pkg, smsq_walk, smsq_duty.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  command   | start, busy             | i_reverse
//  result    | o_strobe                | o_coil_[a-d]_duty, o_hold_us, o_last
//  config    | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// A command keeps busy high while it yields 4 << mode words (4 at full step, 64 at
// sixteenth step), one word per cycle from the position adder. The first word
// reaches the result ports through the sequencer state and output word registers;
// the last one in the first cycle with busy low, whose closing edge can take the
// next start. Reset (synchronous, active low) restores mode 4, speed 0, scale 1.
// The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module stepper_microstep_sequencer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_reverse,
    input  wire logic                         i_cfg_we,
    input  wire logic [smsq_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [smsq_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                              o_strobe,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_a_duty,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_b_duty,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_c_duty,
    output logic [smsq_pkg::DUTY_W-1:0]       o_coil_d_duty,
    output logic [smsq_pkg::SPEED_W-1:0]      o_hold_us,
    output logic                              o_last
);
    import smsq_pkg::*;

    logic [MODE_W-1:0]  r_step_mode;
    logic [SPEED_W-1:0] r_motor_speed;
    logic [SCALE_W-1:0] r_pwm_scale;

    logic [MODE_W-1:0]  mode;
    logic [SCALE_W-1:0] scale;
    logic [SPEED_W-1:0] hold;
    t_walk              walk;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_mode   <= MAX_MODE;
            r_motor_speed <= '0;
            r_pwm_scale   <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP_MODE:   r_step_mode   <= i_cfg_data[MODE_W-1:0];
                REG_MOTOR_SPEED: r_motor_speed <= i_cfg_data[SPEED_W-1:0];
                REG_PWM_SCALE:   r_pwm_scale   <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp mode and scale to four
    assign mode  = (r_step_mode > MAX_MODE) ? MAX_MODE : r_step_mode;
    assign scale = (r_pwm_scale > MAX_SCALE) ? MAX_SCALE : r_pwm_scale;
    assign hold  = r_motor_speed >> mode;

    smsq_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_reverse (i_reverse),
        .i_mode    (mode),
        .busy      (busy),
        .o_walk    (walk)
    );

    smsq_duty u_duty (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_walk        (walk),
        .i_scale       (scale),
        .i_hold        (hold),
        .o_strobe      (o_strobe),
        .o_coil_a_duty (o_coil_a_duty),
        .o_coil_b_duty (o_coil_b_duty),
        .o_coil_c_duty (o_coil_c_duty),
        .o_coil_d_duty (o_coil_d_duty),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
